>>> hdl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the stop-and-wait segment sender.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int LENGTH_WIDTH = 32;

    localparam int LEN_W   = 32;
    localparam int SIZE_W  = 16;
    localparam int TIMER_W = 24;
    localparam int SEQ_W   = 8;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;
    localparam int OUT_W   = SEQ_W + LEN_W + SIZE_W;

    // Only the low LENGTH_WIDTH bits of the configured file length count.
    localparam logic [63:0] LEN_MASK64 = (64'd1 << LENGTH_WIDTH) - 64'd1;
    localparam logic [LEN_W-1:0] LEN_MASK = LEN_MASK64[LEN_W-1:0];

    localparam int DIV_STEPS = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_FILE_LENGTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SEGMENT_SIZE = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT      = 2'd2;
    localparam logic [IDX_W-1:0] REG_INITIAL_SEQ  = 2'd3;

    localparam logic [LEN_W-1:0]   RST_FILE_LENGTH  = 32'd0;
    localparam logic [SIZE_W-1:0]  RST_SEGMENT_SIZE = 16'd1024;
    localparam logic [TIMER_W-1:0] RST_TIMEOUT      = 24'd1000;
    localparam logic [SEQ_W-1:0]   RST_INITIAL_SEQ  = 8'd0;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PACKET = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef struct packed {
        logic transfer_done;
        logic is_retransmit;
        logic send_valid;
    } sws_user_t;

    typedef struct packed {
        logic start_load;
        logic div_start;
        logic load_total;
        logic advance;
        logic from_start;
        logic build;
        logic retx;
        logic done;
        logic timer_inc;
    } sws_cmd_t;

    typedef struct packed {
        logic busy;
        logic len_zero;
        logic good_ack;
        logic all_sent;
        logic timeout_hit;
        logic div_done;
    } sws_status_t;

endpackage

>>> hdl/sws_div.sv
// ----------------------------------------------------------------------------
// sws_div
// Restoring divider, one quotient bit per cycle, for the segment count.
// ----------------------------------------------------------------------------
module sws_div
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LEN_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [LEN_W-1:0]  quotient,
    output logic              rem_nonzero
);

    logic                 run_reg, run_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0]     q_reg, q_next;
    logic [SIZE_W-1:0]    r_reg, r_next;
    logic [SIZE_W-1:0]    d_reg, d_next;
    logic [SIZE_W+1:0]    diff;
    logic                 ge;

    // The shifted partial remainder is one bit wider than the divisor.
    assign diff = {1'b0, r_reg, q_reg[LEN_W-1]} - {2'b00, d_reg};
    assign ge   = !diff[SIZE_W+1];

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[LEN_W-2:0], ge};
            r_next = ge ? diff[SIZE_W-1:0] : {r_reg[SIZE_W-2:0], q_reg[LEN_W-1]};
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done        = run_reg && (cnt_reg == '0);
    assign quotient    = q_reg;
    assign rem_nonzero = |r_reg;

endmodule

>>> hdl/sws_dpath.sv
// ----------------------------------------------------------------------------
// sws_dpath
// Registers, segment arithmetic and result register of the segment sender.
// ----------------------------------------------------------------------------
module sws_dpath
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              rx_checksum_ok,
    input  logic              rx_is_ack,
    input  logic [SEQ_W-1:0]  rx_seq,
    input  sws_cmd_t          cmd,
    output sws_status_t       status,
    output logic [OUT_W-1:0]  out_data,
    output logic              out_last,
    output sws_user_t         out_user
);

    logic [LEN_W-1:0]   file_length_reg;
    logic [SIZE_W-1:0]  segment_size_reg;
    logic [TIMER_W-1:0] timeout_reg;
    logic [SEQ_W-1:0]   initial_seq_reg;

    logic               busy_reg;
    logic [SEQ_W-1:0]   next_seq_reg;
    logic [LEN_W-1:0]   sent_reg, sent_next;
    logic [LEN_W-1:0]   total_reg;
    logic [TIMER_W-1:0] timer_reg;
    logic [SEQ_W-1:0]   cur_seq_reg;
    logic [LEN_W-1:0]   cur_off_reg;
    logic [SIZE_W-1:0]  cur_len_reg;
    logic               cur_last_reg;
    logic [LEN_W-1:0]   off_reg;
    logic               last_reg;

    logic [OUT_W-1:0]   out_data_reg;
    logic               out_last_reg;
    sws_user_t          out_user_reg;

    logic [LEN_W-1:0]   eff_len;
    logic [SIZE_W-1:0]  eff_size;
    logic [LEN_W-1:0]   tail_len;
    logic [SIZE_W-1:0]  new_len;
    logic               div_done;
    logic [LEN_W-1:0]   div_q;
    logic               div_rem_nz;

    assign eff_len  = file_length_reg & LEN_MASK;
    assign eff_size = (segment_size_reg == '0) ? SIZE_W'(1) : segment_size_reg;
    assign tail_len = eff_len - off_reg;
    assign new_len  = last_reg ? tail_len[SIZE_W-1:0] : eff_size;
    assign sent_next = sent_reg + 1'b1;

    sws_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.div_start),
        .dividend    (eff_len),
        .divisor     (eff_size),
        .done        (div_done),
        .quotient    (div_q),
        .rem_nonzero (div_rem_nz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg  <= RST_FILE_LENGTH;
            segment_size_reg <= RST_SEGMENT_SIZE;
            timeout_reg      <= RST_TIMEOUT;
            initial_seq_reg  <= RST_INITIAL_SEQ;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILE_LENGTH:  file_length_reg  <= cfg_data[LEN_W-1:0];
                REG_SEGMENT_SIZE: segment_size_reg <= cfg_data[SIZE_W-1:0];
                REG_TIMEOUT:      timeout_reg      <= cfg_data[TIMER_W-1:0];
                REG_INITIAL_SEQ:  initial_seq_reg  <= cfg_data[SEQ_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            next_seq_reg <= '0;
            sent_reg     <= '0;
            total_reg    <= '0;
            timer_reg    <= '0;
            cur_seq_reg  <= '0;
            cur_off_reg  <= '0;
            cur_len_reg  <= '0;
            cur_last_reg <= 1'b0;
            off_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start_load)
            begin
                next_seq_reg <= initial_seq_reg;
                sent_reg     <= '0;
                total_reg    <= '0;
                timer_reg    <= '0;
                cur_seq_reg  <= '0;
                cur_off_reg  <= '0;
                cur_len_reg  <= '0;
                cur_last_reg <= 1'b0;
            end
            if (cmd.load_total)
            begin
                total_reg <= div_q + LEN_W'(div_rem_nz);
            end
            // First half of a new segment: its index, offset and last flag.
            if (cmd.advance)
            begin
                sent_reg <= sent_next;
                last_reg <= (sent_next == total_reg);
                off_reg  <= cmd.from_start ? '0 : cur_off_reg + LEN_W'(cur_len_reg);
            end
            if (cmd.build)
            begin
                busy_reg     <= 1'b1;
                cur_seq_reg  <= next_seq_reg;
                cur_off_reg  <= off_reg;
                cur_len_reg  <= new_len;
                cur_last_reg <= last_reg;
                next_seq_reg <= next_seq_reg + 1'b1;
                timer_reg    <= '0;
            end
            if (cmd.retx)
            begin
                timer_reg <= '0;
            end
            if (cmd.done)
            begin
                busy_reg  <= 1'b0;
                timer_reg <= '0;
            end
            if (cmd.timer_inc)
            begin
                timer_reg <= timer_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build)
        begin
            out_data_reg <= {new_len, off_reg, next_seq_reg};
            out_last_reg <= last_reg;
            out_user_reg <= '{transfer_done: 1'b0, is_retransmit: 1'b0, send_valid: 1'b1};
        end
        else if (cmd.retx)
        begin
            out_data_reg <= {cur_len_reg, cur_off_reg, cur_seq_reg};
            out_last_reg <= cur_last_reg;
            out_user_reg <= '{transfer_done: 1'b0, is_retransmit: 1'b1, send_valid: 1'b1};
        end
        else if (cmd.done)
        begin
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
            out_user_reg <= '{transfer_done: 1'b1, is_retransmit: 1'b0, send_valid: 1'b0};
        end
    end

    assign status.busy        = busy_reg;
    assign status.len_zero    = (eff_len == '0);
    assign status.good_ack    = rx_checksum_ok && rx_is_ack && (rx_seq == next_seq_reg);
    assign status.all_sent    = (sent_reg == total_reg);
    assign status.timeout_hit = (timer_reg >= timeout_reg);
    assign status.div_done    = div_done;

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
    assign out_user = out_user_reg;

`ifndef SYNTHESIS
    a_build_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build |=> busy_reg)
        else $error("segment built without entering the busy state");

    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> (!busy_reg && out_user_reg.transfer_done && !out_user_reg.send_valid))
        else $error("done result malformed or transfer still busy");
`endif

endmodule

>>> hdl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl
// Sequencer of the segment sender: decodes events and steps the datapath.
// ----------------------------------------------------------------------------
module sws_ctrl
    import sws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  op,
    input  logic        out_ready,
    input  sws_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output sws_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_TOTAL = 6'b000100,
        ST_FIRST = 6'b001000,
        ST_BUILD = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_START:
                        begin
                            if (!status.busy)
                            begin
                                cmd.start_load = 1'b1;
                                if (status.len_zero)
                                begin
                                    cmd.done   = 1'b1;
                                    state_next = ST_OUT;
                                end
                                else
                                begin
                                    cmd.div_start = 1'b1;
                                    state_next    = ST_DIV;
                                end
                            end
                        end
                        OP_PACKET:
                        begin
                            if (status.busy)
                            begin
                                if (!status.good_ack)
                                begin
                                    cmd.retx   = 1'b1;
                                    state_next = ST_OUT;
                                end
                                else if (status.all_sent)
                                begin
                                    cmd.done   = 1'b1;
                                    state_next = ST_OUT;
                                end
                                else
                                begin
                                    cmd.advance = 1'b1;
                                    state_next  = ST_BUILD;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (status.busy)
                            begin
                                if (status.timeout_hit)
                                begin
                                    cmd.retx   = 1'b1;
                                    state_next = ST_OUT;
                                end
                                else
                                begin
                                    cmd.timer_inc = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                cmd.load_total = 1'b1;
                state_next     = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.advance    = 1'b1;
                cmd.from_start = 1'b1;
                state_next     = ST_BUILD;
            end
            ST_BUILD:
            begin
                cmd.build  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_div_to_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_done) |=> (state_reg == ST_TOTAL))
        else $error("segment count not loaded after division");

    a_retx_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retx |-> status.busy)
        else $error("retransmission while no transfer is active");
`endif

endmodule

>>> hdl/stop_and_wait_segment_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_segment_sender
// Stop-and-wait sender: cuts a transfer into segments and issues send,
// retransmit and done descriptors from start, packet and tick events.
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                          beat carries
//  s_axis   in         tvalid tready tdata[15:0] tuser  one event
//  m_axis   out        tvalid tready tdata[55:0] tlast  one descriptor
//                      tuser[2:0]
//  cfg      in         valid ready index[1:0] data[31:0] one register write
//
// One event is handled at a time. A tick that only counts is taken in idle and gives no
// beat; for a retransmit or done, its beat appears in the cycle after the input beat.
// A new segment passes through the build state before its beat. A start runs the 32-step
// segment count divider, then the total, first and build states, before its beat.
// A pending output beat holds the input side until m_axis_tready takes it.
// Reset clears the control state and loads the register defaults; cfg is always ready.
//
module stop_and_wait_segment_sender
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // rx_checksum_ok, rx_is_ack, rx_seq[7:0], pad
    input  logic [1:0]        s_axis_tuser,  // operation[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,  // seg_seq[7:0], seg_offset[31:0], seg_length[15:0]
    output logic              m_axis_tlast,  // seg_last
    output logic [2:0]        m_axis_tuser,  // send_valid, is_retransmit, transfer_done
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    sws_cmd_t    cmd;
    sws_status_t status;
    sws_user_t   out_user;
    logic        in_beat_valid;

    assign cfg_ready     = 1'b1;
    assign in_beat_valid = s_axis_tvalid;

    sws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_beat_valid),
        .op        (s_axis_tuser),
        .out_ready (m_axis_tready),
        .status    (status),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    sws_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_checksum_ok (s_axis_tdata[0]),
        .rx_is_ack      (s_axis_tdata[1]),
        .rx_seq         (s_axis_tdata[SEQ_W+1:2]),
        .cmd            (cmd),
        .status         (status),
        .out_data       (m_axis_tdata),
        .out_last       (m_axis_tlast),
        .out_user       (out_user)
    );

    assign m_axis_tuser = out_user;

endmodule

>>> tb/tb_stop_and_wait_segment_sender.sv
// ----------------------------------------------------------------------------
// tb_stop_and_wait_segment_sender
// Self-checking bench for the stop-and-wait segment sender. Start, packet and
// tick events stream into the block. A built-in predictor of the sender works
// out each descriptor, and every output beat is compared field by field with
// the oldest one waiting. A directed prologue is followed by randomized
// transfers under several register settings, with random idling on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_segment_sender;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    // The one operation code the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       ck;
        logic       ack;
        logic [7:0] rseq;
    } rx_event_t;

    typedef struct packed {
        logic [7:0]  seq;
        logic [31:0] offset;
        logic [15:0] length;
        logic        last;
    } segment_t;

    typedef struct packed {
        logic     send;
        logic     retx;
        logic     done;
        segment_t seg;
    } descriptor_t;

    typedef struct {
        logic [31:0] file_len;
        logic [15:0] seg_size;
        logic [23:0] tmo;
        logic [7:0]  init_seq;
        bit          busy;
        logic [7:0]  next_seq;
        logic [31:0] sent;
        logic [31:0] total;
        logic [23:0] timer;
        segment_t    cur;
    } sender_model_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;   // rx_checksum_ok, rx_is_ack, rx_seq[7:0], pad
    logic [1:0]        s_axis_tuser = '0;   // operation[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // seg_seq[7:0], seg_offset[31:0], seg_length[15:0]
    logic              m_axis_tlast;        // seg_last
    logic [2:0]        m_axis_tuser;        // send_valid, is_retransmit, transfer_done
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // Two copies of the sender: one follows the accepted beats, the other runs
    // ahead at generation time so that the stimulus knows the next sequence.
    sender_model_t model_dut;
    sender_model_t model_gen;

    rx_event_t   event_q[$];
    descriptor_t descr_q[$];

    int  n_push = 0;
    int  n_acc = 0;
    int  n_live = 0;
    int  n_fail = 0;
    bit  idle_on = 1'b1;
    bit  calm = 1'b0;
    int  hold_asks = 0;

    rx_event_t   drv_ev;
    descriptor_t drv_d;
    int          drv_gap = 0;

    descriptor_t mon_want;
    descriptor_t mon_got;
    int          mon_stall = 0;
    int          mon_hold = 0;
    int          hold_seen = 0;

    stop_and_wait_segment_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // A segment size of zero behaves as one byte.
    function automatic logic [15:0] size_of(input sender_model_t m);
        return (m.seg_size == 16'd0) ? 16'd1 : m.seg_size;
    endfunction

    function automatic void apply_reg(inout sender_model_t m, input logic [IDX_W-1:0] idx,
                                      input logic [31:0] v);
        case (idx)
            REG_FILE_LENGTH:  m.file_len = v;
            REG_SEGMENT_SIZE: m.seg_size = v[15:0];
            REG_TIMEOUT:      m.tmo = v[23:0];
            REG_INITIAL_SEQ:  m.init_seq = v[7:0];
            default: ;
        endcase
    endfunction

    function automatic void send_segment(inout sender_model_t m, input logic [31:0] off,
                                         output descriptor_t d);
        logic [31:0] len32;
        logic        last;
        len32 = m.file_len & LEN_MASK;
        m.sent = m.sent + 32'd1;
        last = (m.sent == m.total);
        d = '0;
        d.send = 1'b1;
        d.seg.seq = m.next_seq;
        d.seg.offset = off;
        // The final segment carries whatever remains, a full one on an exact multiple.
        d.seg.length = last ? (len32[15:0] - off[15:0]) : size_of(m);
        d.seg.last = last;
        m.cur = d.seg;
        m.next_seq = m.next_seq + 8'd1;
        m.timer = '0;
    endfunction

    function automatic bit step_sender(inout sender_model_t m, input rx_event_t ev,
                                       output descriptor_t d);
        logic [31:0] len32;
        logic [31:0] size32;
        d = '0;
        if (ev.op == OP_START)
        begin
            if (m.busy)
                return 1'b0;
            len32 = m.file_len & LEN_MASK;
            size32 = {16'd0, size_of(m)};
            m.next_seq = m.init_seq;
            m.sent = '0;
            m.timer = '0;
            m.cur = '0;
            m.total = len32 / size32 + (((len32 % size32) != 32'd0) ? 32'd1 : 32'd0);
            if (m.total == 32'd0)
            begin
                d.done = 1'b1;
                return 1'b1;
            end
            m.busy = 1'b1;
            send_segment(m, 32'd0, d);
            return 1'b1;
        end
        if (!m.busy || (ev.op != OP_PACKET && ev.op != OP_TICK))
            return 1'b0;
        if (ev.op == OP_PACKET)
        begin
            if (ev.ck && ev.ack && ev.rseq == m.next_seq)
            begin
                if (m.sent == m.total)
                begin
                    m.busy = 1'b0;
                    m.timer = '0;
                    d.done = 1'b1;
                    return 1'b1;
                end
                send_segment(m, m.cur.offset + {16'd0, m.cur.length}, d);
                return 1'b1;
            end
            // Anything but the awaited ACK asks for the current segment again.
            m.timer = '0;
            d.send = 1'b1;
            d.retx = 1'b1;
            d.seg = m.cur;
            return 1'b1;
        end
        if (m.timer >= m.tmo)
        begin
            m.timer = '0;
            d.send = 1'b1;
            d.retx = 1'b1;
            d.seg = m.cur;
            return 1'b1;
        end
        m.timer = m.timer + 24'd1;
        return 1'b0;
    endfunction

    // Event driver: the beat on the bus is predicted at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            drv_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (step_sender(model_dut, drv_ev, drv_d))
                    descr_q.push_back(drv_d);
                n_acc++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (event_q.size() > 0)
                begin
                    drv_ev = event_q.pop_front();
                    s_axis_tuser <= drv_ev.op;
                    s_axis_tdata <= {6'd0, drv_ev.rseq, drv_ev.ack, drv_ev.ck};
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && !calm && $urandom_range(0, 3) == 0)
                        drv_gap = $urandom_range(1, 16);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Descriptor monitor and receiver-side back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            mon_stall = 0;
            mon_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                mon_got.send = m_axis_tuser[0];
                mon_got.retx = m_axis_tuser[1];
                mon_got.done = m_axis_tuser[2];
                mon_got.seg.seq = m_axis_tdata[7:0];
                mon_got.seg.offset = m_axis_tdata[39:8];
                mon_got.seg.length = m_axis_tdata[55:40];
                mon_got.seg.last = m_axis_tlast;
                if (descr_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t unexpected descriptor: %p", $realtime, mon_got);
                end
                else
                begin
                    mon_want = descr_q.pop_front();
                    if (mon_got.send !== mon_want.send || mon_got.retx !== mon_want.retx
                        || mon_got.done !== mon_want.done
                        || mon_got.seg.seq !== mon_want.seg.seq
                        || mon_got.seg.offset !== mon_want.seg.offset
                        || mon_got.seg.length !== mon_want.seg.length
                        || mon_got.seg.last !== mon_want.seg.last)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("%0t descriptor mismatch: expected %p got %p",
                                     $realtime, mon_want, mon_got);
                    end
                end
            end
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                mon_hold = 300;
            end
            if (mon_hold > 0)
            begin
                mon_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (mon_stall > 0)
            begin
                mon_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && !calm && $urandom_range(0, 7) == 0)
            begin
                mon_stall = $urandom_range(1, 16) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(model_dut, idx, value);
        apply_reg(model_gen, idx, value);
        @(posedge clk);
    endtask

    // Unused upper data bits are filled with noise when junk is set.
    task automatic configure(input logic [31:0] flen, input logic [15:0] size,
                             input logic [23:0] tmo, input logic [7:0] seq, input bit junk);
        logic [31:0] noise;
        noise = junk ? $urandom() : 32'd0;
        write_reg(REG_FILE_LENGTH, flen);
        write_reg(REG_SEGMENT_SIZE, {noise[31:16], size});
        write_reg(REG_TIMEOUT, {noise[7:0], tmo});
        write_reg(REG_INITIAL_SEQ, {noise[23:0], seq});
    endtask

    task automatic push_ev(input logic [1:0] op, input logic ck, input logic ack,
                           input logic [7:0] rseq);
        rx_event_t   ev;
        descriptor_t d;
        bit          was_busy;
        ev = '{op: op, ck: ck, ack: ack, rseq: rseq};
        was_busy = model_gen.busy;
        if (step_sender(model_gen, ev, d) || (op == OP_TICK && was_busy))
            n_live++;
        event_q.push_back(ev);
        n_push++;
    endtask

    // Mostly well-formed transfers, with corrupt packets, ticks and noise mixed in.
    task automatic random_transfers(input int n);
        int          target;
        int          r;
        logic        ck;
        logic        ack;
        logic [7:0]  rseq;
        target = n_live + n;
        while (n_live < target)
        begin
            r = $urandom_range(0, 99);
            ck = 1'($urandom_range(0, 1));
            ack = 1'($urandom_range(0, 1));
            rseq = 8'($urandom_range(0, 255));
            if (!model_gen.busy)
            begin
                if (r < 80)
                    push_ev(OP_START, ck, ack, rseq);
                else
                    push_ev(2'($urandom_range(0, 3)), ck, ack, rseq);
            end
            else if (r < 60)
                push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
            else if (r < 70)
            begin
                if (ck && ack && rseq == model_gen.next_seq)
                    rseq = rseq + 8'd1;
                push_ev(OP_PACKET, ck, ack, rseq);
            end
            else if (r < 92)
                push_ev(OP_TICK, ck, ack, rseq);
            else if (r < 96)
                push_ev(OP_START, ck, ack, rseq);
            else
                push_ev(OP_UNUSED, ck, ack, rseq);
        end
    endtask

    // A start may still be counting segments after the last descriptor left.
    task automatic drain_wait();
        while (n_acc != n_push || descr_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        int          p;
        logic [15:0] size;
        logic [31:0] eff;
        logic [31:0] flen;
        logic [23:0] tmo;

        model_dut.file_len = RST_FILE_LENGTH;
        model_dut.seg_size = RST_SEGMENT_SIZE;
        model_dut.tmo = RST_TIMEOUT;
        model_dut.init_seq = RST_INITIAL_SEQ;
        model_dut.busy = 1'b0;
        model_dut.next_seq = '0;
        model_dut.sent = '0;
        model_dut.total = '0;
        model_dut.timer = '0;
        model_dut.cur = '0;
        model_gen = model_dut;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset defaults: an empty transfer, then events the idle block ignores.
        push_ev(OP_START, 1'b0, 1'b0, 8'd0);
        push_ev(OP_TICK, 1'b1, 1'b1, 8'hFF);
        push_ev(OP_PACKET, 1'b1, 1'b1, 8'd0);
        push_ev(OP_UNUSED, 1'b0, 1'b0, 8'd0);
        drain_wait();

        // Three segments with a short tail, sequence wrapping through 255,
        // every kind of rejected packet and an immediate timeout.
        configure(32'd10, 16'd4, 24'd0, 8'd254, 1'b0);
        push_ev(OP_START, 1'b0, 1'b0, 8'd0);
        push_ev(OP_PACKET, 1'b0, 1'b1, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b0, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq + 8'd1);
        push_ev(OP_TICK, 1'b0, 1'b0, 8'd0);
        push_ev(OP_START, 1'b1, 1'b1, 8'hFF);
        push_ev(OP_UNUSED, 1'b1, 1'b1, 8'hFF);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        drain_wait();

        // Exact multiple: the last segment is full; timeout after two idle ticks.
        configure(32'd8, 16'd4, 24'd2, 8'd0, 1'b0);
        push_ev(OP_START, 1'b0, 1'b0, 8'd0);
        push_ev(OP_TICK, 1'b0, 1'b0, 8'd0);
        push_ev(OP_TICK, 1'b0, 1'b0, 8'd0);
        push_ev(OP_TICK, 1'b0, 1'b0, 8'd0);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        drain_wait();

        // Segment size zero acts as one byte.
        configure(32'd2, 16'd0, 24'd1, 8'd128, 1'b1);
        push_ev(OP_START, 1'b0, 1'b0, 8'd0);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        push_ev(OP_PACKET, 1'b1, 1'b1, model_gen.next_seq);
        drain_wait();

        for (p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 9))
                0:       size = 16'd0;
                1:       size = 16'($urandom_range(1, 65535));
                2:       size = 16'hFFFF;
                default: size = 16'($urandom_range(1, 16));
            endcase
            eff = (size == 16'd0) ? 32'd1 : {16'd0, size};
            case ($urandom_range(0, 7))
                0:       flen = 32'd0;
                1:       flen = eff * 32'($urandom_range(1, 6));
                default: flen = 32'($urandom_range(1, eff * 6));
            endcase
            case ($urandom_range(0, 5))
                0:       tmo = 24'd0;
                1:       tmo = 24'($urandom_range(7, 16777215));
                default: tmo = 24'($urandom_range(1, 6));
            endcase
            idle_on = (p % 3) != 2;
            configure(flen, size, tmo, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            if (p == 3)
                hold_asks++;
            random_transfers(95);
            drain_wait();
        end

        // Largest settings, with no idling at all; this transfer never ends.
        calm = 1'b1;
        configure(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF, 1'b1);
        random_transfers(50);
        drain_wait();

        if (n_fail == 0 && descr_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
